// ===== src/grid_charge_potential_eval_macros.svh =====
// assertion macros used by the checker file
`ifndef GRID_CHARGE_POTENTIAL_EVAL_MACROS_SVH
`define GRID_CHARGE_POTENTIAL_EVAL_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define GCPE_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define GCPE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/gcpe_pkg.sv =====
// types and constants of the charge potential evaluator
`timescale 1ns / 1ps

package gcpe_pkg;

  // opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_ACTIVE_POINTS   = 2'd0;
  localparam logic [1:0] CFG_MIRROR_HEIGHT   = 2'd1;
  localparam logic [1:0] CFG_POTENTIAL_SCALE = 2'd2;

  localparam logic [8:0] ACTIVE_POINTS_RESET = 9'd20;

  // datapath widths
  localparam int SQ_W       = 48;  // squared axis term, Q.16
  localparam int DIST_W     = 50;  // sum of three squared terms
  localparam int QUOT_W     = 49;  // floor(2^48 / d)
  localparam int ROOT_W     = 25;  // inverse root, at most 2^24
  localparam int MAG_W      = 48;  // scale times voltage magnitude
  localparam int PP_CHUNK_W = 16;  // slice of MAG_W per partial product
  localparam int PP_STEPS   = 3;
  localparam int OUT_SHIFT  = 36;
  localparam logic [63:0] ROUND_BIAS = 64'h0000_0008_0000_0000;

  // command queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

  typedef struct packed {
    logic               opcode;
    logic [7:0]         point_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] probe_z;
    logic signed [15:0] drive_voltage;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] potential;
    logic               saturated;
  } out_item_t;

  // classified transaction held between front and back
  typedef struct packed {
    logic               is_eval;
    logic               wr_ok;
    logic               z_neg;
    logic [7:0]         point_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] probe_z;
    logic signed [15:0] drive_voltage;
  } cmd_t;

  typedef enum logic [1:0] {
    IR_IDLE,
    IR_DIV,
    IR_SQRT
  } ir_state_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_ZZ,
    BK_ZM,
    BK_RD,
    BK_SQX,
    BK_SQY,
    BK_DIR,
    BK_DIRW,
    BK_MIR,
    BK_MIRW,
    BK_MAG,
    BK_PROD,
    BK_DONE
  } bk_state_e;

endpackage

// ===== src/grid_charge_potential_eval.sv =====
// top level of the charge point potential evaluator
`timescale 1ns / 1ps

// potential at a probe point from a table of charge points and their image
// charges. a write transaction stores one point (x, y); an evaluate
// transaction sums 1/sqrt(r^2+z^2) - 1/sqrt(r^2+(m-z)^2) over the active points
// and returns round(scale * voltage * sum / 2^36), saturated to 32 bits, with
// a flag when it clips. a negative probe height returns zero. a write
// transaction is stored straight from the idle state of the back end; an
// evaluate transaction loops over the active points, unless nothing is summed.
// its run time is set by the shared inverse root unit, which spends 49 restoring
// divide steps and 25 root digit steps on each of the two distances per point.
// a two-entry queue lets new transactions be taken while the back end works,
// and the result register lets the next evaluation run while a result waits.
// table entries must be written before they are read; there is no clear pass.

module grid_charge_potential_eval #(
  parameter int unsigned MAX_POINTS = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input transactions
  input  gcpe_pkg::in_item_t  item_i,
  input  logic                push,
  output logic                full,
  // result transactions
  output gcpe_pkg::out_item_t result_o,
  output logic                empty,
  input  logic                pop,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i
);

  // configuration registers
  logic [8:0]  active_points_q;
  logic [30:0] mirror_height_q;
  logic [31:0] potential_scale_q;

  // front to back queue head
  gcpe_pkg::cmd_t cmd;
  logic           cmd_valid;
  logic           cmd_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_points_q   <= gcpe_pkg::ACTIVE_POINTS_RESET;
      mirror_height_q   <= '0;
      potential_scale_q <= '0;
    end else if (cfg_we_i) begin
      // writes to unknown indexes fall through and are dropped
      case (cfg_idx_i)
        gcpe_pkg::CFG_ACTIVE_POINTS:   active_points_q   <= cfg_data_i[8:0];
        gcpe_pkg::CFG_MIRROR_HEIGHT:   mirror_height_q   <= cfg_data_i[30:0];
        gcpe_pkg::CFG_POTENTIAL_SCALE: potential_scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // accept and classify
  gcpe_front #(
    .MAX_POINTS (MAX_POINTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .push_i      (push),
    .full_o      (full),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  // table, summation loop, scaling and result register
  gcpe_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .cmd_valid_i       (cmd_valid),
    .cmd_pop_o         (cmd_pop),
    .active_points_i   (active_points_q),
    .mirror_height_i   (mirror_height_q),
    .potential_scale_i (potential_scale_q),
    .result_o          (result_o),
    .empty_o           (empty),
    .pop_i             (pop)
  );

endmodule

// ===== src/gcpe_ram.sv =====
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module gcpe_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/gcpe_inv_root.sv =====
// iterative inverse square root: floor(sqrt(floor(2^48 / d)))
`timescale 1ns / 1ps

module gcpe_inv_root (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [gcpe_pkg::DIST_W-1:0] dist_i,
  output logic                        done_o,
  output logic [gcpe_pkg::ROOT_W-1:0] root_o
);

  localparam int DW = gcpe_pkg::DIST_W;
  localparam int RW = gcpe_pkg::ROOT_W;

  gcpe_pkg::ir_state_e state_q, state_d;
  logic [DW-1:0] den_q, den_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] quot_q, quot_d;
  logic [5:0]    cnt_q, cnt_d;
  logic [RW-1:0] root_q, root_d;
  logic [RW:0]   srem_q, srem_d;
  logic          done_q, done_d;

  logic [DW:0]   rem_sh;
  logic [RW+2:0] srem_sh;
  logic [RW+2:0] trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gcpe_pkg::IR_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q  <= den_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
    cnt_q  <= cnt_d;
    root_q <= root_d;
    srem_q <= srem_d;
  end

  always_comb begin
    state_d = state_q;
    den_d   = den_q;
    rem_d   = rem_q;
    quot_d  = quot_q;
    cnt_d   = cnt_q;
    root_d  = root_q;
    srem_d  = srem_q;
    done_d  = 1'b0;
    // the dividend is 2^48: its only set bit enters on the first step
    rem_sh  = {rem_q, (cnt_q == 6'(gcpe_pkg::QUOT_W - 1))};
    srem_sh = {srem_q, quot_q[DW-1 -: 2]};
    trial   = {1'b0, root_q, 2'b01};
    unique case (state_q)
      gcpe_pkg::IR_IDLE: begin
        if (start_i) begin
          den_d   = (dist_i == '0) ? DW'(1) : dist_i;
          rem_d   = '0;
          quot_d  = '0;
          cnt_d   = 6'(gcpe_pkg::QUOT_W - 1);
          state_d = gcpe_pkg::IR_DIV;
        end
      end
      gcpe_pkg::IR_DIV: begin
        if (rem_sh >= {1'b0, den_q}) begin
          rem_d  = DW'(rem_sh - {1'b0, den_q});
          quot_d = {quot_q[DW-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh[DW-1:0];
          quot_d = {quot_q[DW-2:0], 1'b0};
        end
        if (cnt_q == '0) begin
          cnt_d   = 6'(RW - 1);
          srem_d  = '0;
          root_d  = '0;
          state_d = gcpe_pkg::IR_SQRT;
        end else begin
          cnt_d = cnt_q - 6'd1;
        end
      end
      gcpe_pkg::IR_SQRT: begin
        quot_d = {quot_q[DW-3:0], 2'b00};
        if (srem_sh >= trial) begin
          srem_d = (RW+1)'(srem_sh - trial);
          root_d = {root_q[RW-2:0], 1'b1};
        end else begin
          srem_d = srem_sh[RW:0];
          root_d = {root_q[RW-2:0], 1'b0};
        end
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          state_d = gcpe_pkg::IR_IDLE;
        end else begin
          cnt_d = cnt_q - 6'd1;
        end
      end
      default: state_d = gcpe_pkg::IR_IDLE;
    endcase
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== src/gcpe_front.sv =====
// front end: accepts and classifies transactions into a short queue
`timescale 1ns / 1ps

module gcpe_front #(
  parameter int unsigned MAX_POINTS = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gcpe_pkg::in_item_t  item_i,
  input  logic                push_i,
  output logic                full_o,
  output gcpe_pkg::cmd_t      cmd_o,
  output logic                cmd_valid_o,
  input  logic                cmd_pop_i
);

  localparam int PW = gcpe_pkg::QUEUE_PTR_W;
  localparam int CNTW = gcpe_pkg::QUEUE_CNT_W;

  gcpe_pkg::cmd_t  slot_q [gcpe_pkg::QUEUE_DEPTH];
  gcpe_pkg::cmd_t  cmd_new;
  logic [PW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNTW-1:0] count_q, count_d;
  logic            push_ok, pop_ok;

  always_comb begin
    cmd_new.is_eval       = (item_i.opcode == gcpe_pkg::OP_EVAL);
    cmd_new.wr_ok         = (32'(item_i.point_index) < MAX_POINTS);
    cmd_new.z_neg         = item_i.probe_z[31];
    cmd_new.point_index   = item_i.point_index;
    cmd_new.coord_x       = item_i.coord_x;
    cmd_new.coord_y       = item_i.coord_y;
    cmd_new.probe_z       = item_i.probe_z;
    cmd_new.drive_voltage = item_i.drive_voltage;
  end

  assign full_o      = (count_q == CNTW'(gcpe_pkg::QUEUE_DEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = slot_q[rptr_q];
  assign push_ok     = push_i && !full_o;
  assign pop_ok      = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_ok) begin
      wptr_d = (wptr_q == PW'(gcpe_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_ok) begin
      rptr_d = (rptr_q == PW'(gcpe_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      count_d = count_q + 1'b1;
    end else if (pop_ok && !push_ok) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      slot_q[wptr_q] <= cmd_new;
    end
  end

endmodule

// ===== src/gcpe_back.sv =====
// back end: point table, summation sequencer, scaling and result register
`timescale 1ns / 1ps

module gcpe_back #(
  parameter int unsigned MAX_POINTS = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gcpe_pkg::cmd_t      cmd_i,
  input  logic                cmd_valid_i,
  output logic                cmd_pop_o,
  input  logic [8:0]          active_points_i,
  input  logic [30:0]         mirror_height_i,
  input  logic [31:0]         potential_scale_i,
  output gcpe_pkg::out_item_t result_o,
  output logic                empty_o,
  input  logic                pop_i
);

  localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW    = $clog2(MAX_POINTS + 1);
  localparam int SUM_W = gcpe_pkg::ROOT_W + CW + 1;
  localparam int PPW   = SUM_W + gcpe_pkg::PP_CHUNK_W;
  localparam int ACC_W = SUM_W + gcpe_pkg::MAG_W;
  localparam int QW    = ACC_W + 1 - gcpe_pkg::OUT_SHIFT;
  localparam int SQW   = gcpe_pkg::SQ_W;
  localparam int DW    = gcpe_pkg::DIST_W;

  gcpe_pkg::bk_state_e state_q, state_d;

  logic signed [31:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic signed [15:0] v_q, v_d;
  logic [SQW-1:0]     zz_q, zz_d, zm_q, zm_d, sqx_q, sqx_d, sqy_q, sqy_d;
  logic [CW-1:0]      n_q, n_d, i_q, i_d;
  logic [gcpe_pkg::ROOT_W-1:0] rdir_q, rdir_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [SUM_W-1:0]   sabs_q, sabs_d;
  logic [gcpe_pkg::MAG_W-1:0] mag_q, mag_d;
  logic               neg_q, neg_d;
  logic [1:0]         pp_q, pp_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  gcpe_pkg::out_item_t out_q, out_d;
  logic               out_valid_q, out_valid_d;

  // table ram
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [63:0]   ram_wdata, ram_rdata;

  // inverse root unit
  logic                        ir_start, ir_done;
  logic [DW-1:0]               ir_dist;
  logic [gcpe_pkg::ROOT_W-1:0] ir_root;

  // arithmetic
  logic [31:0]        mul_a;
  logic [63:0]        prod;
  logic [SQW:0]       r2;
  logic [DW-1:0]      dist_dir, dist_mir;
  logic [15:0]        vabs;
  logic [15:0]        chunk;
  logic [PPW-1:0]     part;
  logic [ACC_W:0]     rnd;
  logic [QW-1:0]      qv, lim, qc;
  logic               neg_eff, sat, out_free;

  function automatic logic [31:0] mag_clamp(input logic signed [32:0] d);
    logic [32:0] m;
    m = d[32] ? 33'(-d) : 33'(d);
    return m[32] ? 32'hFFFF_FFFF : m[31:0];
  endfunction

  gcpe_ram #(
    .WIDTH (64),
    .DEPTH (MAX_POINTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  gcpe_inv_root u_inv_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ir_start),
    .dist_i  (ir_dist),
    .done_o  (ir_done),
    .root_o  (ir_root)
  );

  assign prod     = 64'(mul_a) * 64'(mul_a);
  assign r2       = (SQW+1)'(sqx_q) + (SQW+1)'(sqy_q);
  assign dist_dir = DW'(r2) + DW'(zz_q);
  assign dist_mir = DW'(r2) + DW'(zm_q);
  assign vabs     = v_q[15] ? 16'(-v_q) : 16'(v_q);
  assign part     = PPW'(sabs_q) * PPW'(chunk);
  assign out_free = !out_valid_q || pop_i;

  // rounding, sign and saturation of the final product
  assign rnd     = {1'b0, acc_q} + (ACC_W+1)'(gcpe_pkg::ROUND_BIAS);
  assign qv      = rnd[ACC_W:gcpe_pkg::OUT_SHIFT];
  assign neg_eff = neg_q && (qv != '0);
  assign lim     = neg_q ? QW'(32'h8000_0000) : QW'(32'h7FFF_FFFF);
  assign sat     = (qv > lim);
  assign qc      = sat ? lim : qv;

  always_comb begin
    case (pp_q)
      2'd0:    chunk = mag_q[15:0];
      2'd1:    chunk = mag_q[31:16];
      2'd2:    chunk = mag_q[47:32];
      default: chunk = '0;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    x_d = x_q; y_d = y_q; z_d = z_q; v_d = v_q;
    zz_d = zz_q; zm_d = zm_q; sqx_d = sqx_q; sqy_d = sqy_q;
    n_d = n_q; i_d = i_q; rdir_d = rdir_q; sum_d = sum_q;
    sabs_d = sabs_q; mag_d = mag_q; neg_d = neg_q; pp_d = pp_q; acc_d = acc_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !pop_i;
    cmd_pop_o   = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = AW'(cmd_i.point_index);
    ram_wdata   = {cmd_i.coord_x, cmd_i.coord_y};
    ram_re      = 1'b0;
    ram_raddr   = i_q[AW-1:0];
    ir_start    = 1'b0;
    ir_dist     = dist_dir;
    mul_a       = mag_clamp(33'(z_q));
    unique case (state_q)
      gcpe_pkg::BK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (!cmd_i.is_eval) begin
            ram_we = cmd_i.wr_ok;
          end else begin
            x_d   = cmd_i.coord_x;
            y_d   = cmd_i.coord_y;
            z_d   = cmd_i.probe_z;
            v_d   = cmd_i.drive_voltage;
            i_d   = '0;
            sum_d = '0;
            n_d   = (32'(active_points_i) > MAX_POINTS) ? CW'(MAX_POINTS)
                                                       : CW'(active_points_i);
            // below the electrode, or nothing to sum: straight to a zero result
            if (cmd_i.z_neg || active_points_i == '0) begin
              state_d = gcpe_pkg::BK_MAG;
            end else begin
              state_d = gcpe_pkg::BK_ZZ;
            end
          end
        end
      end
      gcpe_pkg::BK_ZZ: begin
        mul_a   = mag_clamp(33'(z_q));
        zz_d    = prod[63:16];
        state_d = gcpe_pkg::BK_ZM;
      end
      gcpe_pkg::BK_ZM: begin
        mul_a   = mag_clamp(33'({2'b00, mirror_height_i}) - 33'(z_q));
        zm_d    = prod[63:16];
        state_d = gcpe_pkg::BK_RD;
      end
      gcpe_pkg::BK_RD: begin
        ram_re  = 1'b1;
        state_d = gcpe_pkg::BK_SQX;
      end
      gcpe_pkg::BK_SQX: begin
        mul_a   = mag_clamp(33'(x_q) - 33'(signed'(ram_rdata[63:32])));
        sqx_d   = prod[63:16];
        state_d = gcpe_pkg::BK_SQY;
      end
      gcpe_pkg::BK_SQY: begin
        mul_a   = mag_clamp(33'(y_q) - 33'(signed'(ram_rdata[31:0])));
        sqy_d   = prod[63:16];
        state_d = gcpe_pkg::BK_DIR;
      end
      gcpe_pkg::BK_DIR: begin
        ir_start = 1'b1;
        ir_dist  = dist_dir;
        state_d  = gcpe_pkg::BK_DIRW;
      end
      gcpe_pkg::BK_DIRW: begin
        if (ir_done) begin
          rdir_d  = ir_root;
          state_d = gcpe_pkg::BK_MIR;
        end
      end
      gcpe_pkg::BK_MIR: begin
        ir_start = 1'b1;
        ir_dist  = dist_mir;
        state_d  = gcpe_pkg::BK_MIRW;
      end
      gcpe_pkg::BK_MIRW: begin
        if (ir_done) begin
          sum_d = sum_q + SUM_W'(rdir_q) - SUM_W'(ir_root);
          i_d   = i_q + 1'b1;
          if (i_q + 1'b1 == n_q) begin
            state_d = gcpe_pkg::BK_MAG;
          end else begin
            state_d = gcpe_pkg::BK_RD;
          end
        end
      end
      gcpe_pkg::BK_MAG: begin
        mag_d   = gcpe_pkg::MAG_W'(48'(potential_scale_i) * 48'(vabs));
        neg_d   = sum_q[SUM_W-1] ^ v_q[15];
        sabs_d  = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
        acc_d   = '0;
        pp_d    = '0;
        state_d = gcpe_pkg::BK_PROD;
      end
      gcpe_pkg::BK_PROD: begin
        case (pp_q)
          2'd0:    acc_d = acc_q + ACC_W'(part);
          2'd1:    acc_d = acc_q + (ACC_W'(part) << gcpe_pkg::PP_CHUNK_W);
          default: acc_d = acc_q + (ACC_W'(part) << (2 * gcpe_pkg::PP_CHUNK_W));
        endcase
        pp_d = pp_q + 2'd1;
        if (pp_q == 2'(gcpe_pkg::PP_STEPS - 1)) begin
          state_d = gcpe_pkg::BK_DONE;
        end
      end
      gcpe_pkg::BK_DONE: begin
        if (out_free) begin
          out_d.potential = neg_eff ? -signed'(qc[31:0]) : signed'(qc[31:0]);
          out_d.saturated = sat;
          out_valid_d     = 1'b1;
          state_d         = gcpe_pkg::BK_IDLE;
        end
      end
      default: state_d = gcpe_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gcpe_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d; v_q <= v_d;
    zz_q <= zz_d; zm_q <= zm_d; sqx_q <= sqx_d; sqy_q <= sqy_d;
    n_q <= n_d; i_q <= i_d; rdir_q <= rdir_d; sum_q <= sum_d;
    sabs_q <= sabs_d; mag_q <= mag_d; neg_q <= neg_d; pp_q <= pp_d;
    acc_q <= acc_d; out_q <= out_d;
  end

  assign result_o = out_q;
  assign empty_o  = !out_valid_q;

endmodule

// ===== src/gcpe_checker.sv =====
// port-level checks of the potential evaluator and their bind
`timescale 1ns / 1ps
`include "grid_charge_potential_eval_macros.svh"

module gcpe_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                push,
  input logic                full,
  input gcpe_pkg::out_item_t result_o,
  input logic                empty,
  input logic                pop
);

  // a waiting result holds until it is taken
  `GCPE_ASSERT_NEXT(a_result_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(result_o), "result changed while stalled")

  // a clipped result sits at one of the two limits
  `GCPE_ASSERT_NOW(a_sat_limit, clk_i, rst_ni, !empty && result_o.saturated, result_o.potential == 32'sh7FFF_FFFF || result_o.potential == -32'sh8000_0000, "saturated result not at a limit")

  // the result register only drains through a pop
  `GCPE_ASSERT_NOW(a_drain_by_pop, clk_i, rst_ni, $rose(empty), $past(pop), "result vanished without pop")

  // the queue only becomes full through a push
  `GCPE_ASSERT_NOW(a_full_needs_push, clk_i, rst_ni, $rose(full), $past(push), "queue filled without push")

endmodule

bind grid_charge_potential_eval gcpe_checker u_gcpe_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .push     (push),
  .full     (full),
  .result_o (result_o),
  .empty    (empty),
  .pop      (pop)
);
